// File: rtl/core/wrs_pkg.sv
// warp register scoreboard: shared types, field widths and operation codes
// no dependencies; used by the channel interfaces, the update logic and the top level
`default_nettype none

package wrs_pkg;

   // field widths of one request word
   localparam int FUNC_W  = 3;
   localparam int WARP_W  = 6;
   localparam int REG_W   = 6;
   localparam int SLOTS   = 4;
   localparam int REGS_W  = SLOTS * REG_W;

   // operation codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_RESERVE    = 3'd0,
      FUNC_RELEASE    = 3'd1,
      FUNC_CHECK      = 3'd2,
      FUNC_PENDING    = 3'd3,
      FUNC_LONG_QUERY = 3'd4
   } func_type;

   // one request word
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [WARP_W-1:0] warp;
      logic [REGS_W-1:0] dst_regs;
      logic [REGS_W-1:0] src_regs;
      logic [REG_W-1:0]  pred_reg;
      logic [REG_W-1:0]  addr_reg_a;
      logic [REG_W-1:0]  addr_reg_b;
      logic              long_load;
      logic [REG_W-1:0]  query_reg;
   } req_type;

   // one response word
   typedef struct packed {
      logic hazard;
      logic pending;
      logic long_op;
      logic double_reserve;
   } rsp_type;

   // update logic to top level: write strobe and the response word
   typedef struct packed {
      logic    wr_en;
      rsp_type word;
   } upd_type;

endpackage

`default_nettype wire

// File: rtl/core/wrs_if.sv
// warp register scoreboard: request and response channel interfaces
// depends on wrs_pkg for the field widths
`default_nettype none

interface wrs_req_if;
   logic                         valid;
   logic                         ready;
   logic [wrs_pkg::FUNC_W-1:0]   func;
   logic [wrs_pkg::WARP_W-1:0]   warp;
   logic [wrs_pkg::REGS_W-1:0]   dst_regs;
   logic [wrs_pkg::REGS_W-1:0]   src_regs;
   logic [wrs_pkg::REG_W-1:0]    pred_reg;
   logic [wrs_pkg::REG_W-1:0]    addr_reg_a;
   logic [wrs_pkg::REG_W-1:0]    addr_reg_b;
   logic                         long_load;
   logic [wrs_pkg::REG_W-1:0]    query_reg;

   modport source (
      output valid, func, warp, dst_regs, src_regs, pred_reg,
             addr_reg_a, addr_reg_b, long_load, query_reg,
      input  ready
   );
   modport sink (
      input  valid, func, warp, dst_regs, src_regs, pred_reg,
             addr_reg_a, addr_reg_b, long_load, query_reg,
      output ready
   );
endinterface

interface wrs_rsp_if;
   logic valid;
   logic ready;
   logic hazard;
   logic pending;
   logic long_op;
   logic double_reserve;

   modport source (
      output valid, hazard, pending, long_op, double_reserve,
      input  ready
   );
   modport sink (
      input  valid, hazard, pending, long_op, double_reserve,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/core/wrs_update.sv
// warp register scoreboard: bitmap update and response for one request word
// depends on wrs_pkg for the request, response and update types
`default_nettype none

module wrs_update #(
   parameter int NUM_REGS = 64
) (
   input  wire wrs_pkg::req_type  item,
   input  wire                    warp_ok,
   input  wire [NUM_REGS-1:0]     pend_cur,
   input  wire [NUM_REGS-1:0]     long_cur,
   output logic [NUM_REGS-1:0]    pend_next,
   output logic [NUM_REGS-1:0]    long_next,
   output wrs_pkg::upd_type       upd
);

   localparam int REG_IW = $clog2(NUM_REGS);
   localparam logic [wrs_pkg::REG_W:0] REG_LIMIT = (wrs_pkg::REG_W + 1)'(NUM_REGS);

   // one-hot bit of a register; none for register zero or beyond the file
   function automatic logic [NUM_REGS-1:0] reg_bit(input logic [wrs_pkg::REG_W-1:0] r);
      logic [NUM_REGS-1:0] b;
      b = '0;
      if (r != '0 && {1'b0, r} < REG_LIMIT) begin
         b[r[REG_IW-1:0]] = 1'b1;
      end
      return b;
   endfunction

   logic [NUM_REGS-1:0] dmask;
   logic [NUM_REGS-1:0] all_regs;
   logic                dbl;

   // destination mask, double reserve detection and full operand mask
   always_comb begin
      logic [NUM_REGS-1:0] b;
      dmask    = '0;
      all_regs = '0;
      dbl      = 1'b0;
      for (int s = 0; s < wrs_pkg::SLOTS; s++) begin
         b = reg_bit(item.dst_regs[s*wrs_pkg::REG_W +: wrs_pkg::REG_W]);
         if ((b & (pend_cur | dmask)) != '0) begin
            dbl = 1'b1;
         end
         dmask    = dmask | b;
         all_regs = all_regs | b
                  | reg_bit(item.src_regs[s*wrs_pkg::REG_W +: wrs_pkg::REG_W]);
      end
      all_regs = all_regs | reg_bit(item.pred_reg) | reg_bit(item.addr_reg_a)
               | reg_bit(item.addr_reg_b);
   end

   // operation decode
   always_comb begin
      pend_next = pend_cur;
      long_next = long_cur;
      upd       = '0;
      unique case (item.func)
         wrs_pkg::FUNC_RESERVE: begin
            pend_next = pend_cur | dmask;
            if (item.long_load) begin
               long_next = long_cur | dmask;
            end
            upd.wr_en               = 1'b1;
            upd.word.double_reserve = dbl;
         end
         wrs_pkg::FUNC_RELEASE: begin
            pend_next = pend_cur & ~dmask;
            long_next = long_cur & ~dmask;
            upd.wr_en = 1'b1;
         end
         wrs_pkg::FUNC_CHECK: begin
            upd.word.hazard = (pend_cur & all_regs) != '0;
         end
         wrs_pkg::FUNC_LONG_QUERY: begin
            upd.word.long_op = (long_cur & reg_bit(item.query_reg)) != '0;
         end
         default: begin
         end
      endcase
      upd.word.pending = pend_next != '0;
      // warp beyond the table: no change, all-zero word
      if (!warp_ok) begin
         upd = '0;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/warp_register_scoreboard.sv
// warp register scoreboard: top level with bitmap memories and handshake registers
// depends on wrs_pkg, wrs_if (wrs_req_if, wrs_rsp_if) and wrs_update
`default_nettype none

// Per-warp register scoreboard. Every request word (reserve, release, hazard check,
// pending query, long-op query) gives exactly one response word. A word passes
// through the single update stage: the accepting edge registers the word and
// reads the warp's two bitmaps from the bitmap memories; when the stage moves on,
// the updated bitmaps are written back and the response register is loaded.
// Throughput is one word per clock, set by that single stage; a response held
// back by the receiver stalls the update stage and the request side behind it.
// A write from the word just before is forwarded to the one behind it, so
// back-to-back words on the same warp see the freshest bitmaps. Each warp entry
// has a valid bit cleared by reset, so the scoreboard is empty straight after
// reset with no clearing pass. A request is taken while a response waits, as
// long as the update stage can move on.
module warp_register_scoreboard #(
   parameter int NUM_WARPS = 64,
   parameter int NUM_REGS  = 64
) (
   input  wire       clock,
   input  wire       reset,
   wrs_req_if.sink   req_chan,
   wrs_rsp_if.source rsp_chan
);

   localparam int WARP_IW = (NUM_WARPS > 1) ? $clog2(NUM_WARPS) : 1;
   localparam logic [wrs_pkg::WARP_W:0] WARP_LIMIT = (wrs_pkg::WARP_W + 1)'(NUM_WARPS);

   // bitmap memories and per-entry valid bits
   logic [NUM_REGS-1:0]  pend_mem [NUM_WARPS];
   logic [NUM_REGS-1:0]  long_mem [NUM_WARPS];
   logic [NUM_WARPS-1:0] entry_valid_ff;

   // update stage
   logic                 stage_valid_ff;
   wrs_pkg::req_type     stage_ff;
   logic                 stage_ok_ff;
   logic [NUM_REGS-1:0]  rd_pend_ff;
   logic [NUM_REGS-1:0]  rd_long_ff;
   logic                 rd_valid_ff;

   // last write, for forwarding
   logic                 wr_valid_ff;
   logic [WARP_IW-1:0]   wr_warp_ff;
   logic [NUM_REGS-1:0]  wr_pend_ff;
   logic [NUM_REGS-1:0]  wr_long_ff;

   // response register
   logic                 rsp_valid_ff;
   wrs_pkg::rsp_type     rsp_ff;

   wrs_pkg::req_type     req_word;
   logic                 req_fire;
   logic                 stage_fire;
   logic [WARP_IW-1:0]   req_idx;
   logic [WARP_IW-1:0]   stage_idx;
   logic                 fwd;
   logic [NUM_REGS-1:0]  pend_cur;
   logic [NUM_REGS-1:0]  long_cur;
   logic [NUM_REGS-1:0]  pend_next;
   logic [NUM_REGS-1:0]  long_next;
   wrs_pkg::upd_type     upd;
   logic                 do_write;

   // request word from the channel
   always_comb begin
      req_word.func       = req_chan.func;
      req_word.warp       = req_chan.warp;
      req_word.dst_regs   = req_chan.dst_regs;
      req_word.src_regs   = req_chan.src_regs;
      req_word.pred_reg   = req_chan.pred_reg;
      req_word.addr_reg_a = req_chan.addr_reg_a;
      req_word.addr_reg_b = req_chan.addr_reg_b;
      req_word.long_load  = req_chan.long_load;
      req_word.query_reg  = req_chan.query_reg;
   end

   // handshake
   assign stage_fire     = stage_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !stage_valid_ff || stage_fire;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign req_idx   = req_chan.warp[WARP_IW-1:0];
   assign stage_idx = stage_ff.warp[WARP_IW-1:0];

   // freshest bitmaps for the word in the update stage
   assign fwd = wr_valid_ff && (wr_warp_ff == stage_idx);
   always_comb begin
      if (fwd) begin
         pend_cur = wr_pend_ff;
         long_cur = wr_long_ff;
      end else if (rd_valid_ff) begin
         pend_cur = rd_pend_ff;
         long_cur = rd_long_ff;
      end else begin
         pend_cur = '0;
         long_cur = '0;
      end
   end

   wrs_update #(
      .NUM_REGS (NUM_REGS)
   ) u_update (
      .item      (stage_ff),
      .warp_ok   (stage_ok_ff),
      .pend_cur  (pend_cur),
      .long_cur  (long_cur),
      .pend_next (pend_next),
      .long_next (long_next),
      .upd       (upd)
   );

   assign do_write = stage_fire && upd.wr_en;

   // bitmap memories: read on acceptance, write on update
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_pend_ff <= pend_mem[req_idx];
         rd_long_ff <= long_mem[req_idx];
      end
      if (do_write) begin
         pend_mem[stage_idx] <= pend_next;
         long_mem[stage_idx] <= long_next;
      end
   end

   // entry valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         if (req_fire) begin
            rd_valid_ff <= entry_valid_ff[req_idx];
         end
         if (do_write) begin
            entry_valid_ff[stage_idx] <= 1'b1;
         end
      end
   end

   // update stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_fire) begin
         stage_valid_ff <= 1'b1;
      end else if (stage_fire) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_ff    <= req_word;
         stage_ok_ff <= {1'b0, req_chan.warp} < WARP_LIMIT;
      end
   end

   // last write, kept for forwarding
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
      end else if (do_write) begin
         wr_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         wr_warp_ff <= stage_idx;
         wr_pend_ff <= pend_next;
         wr_long_ff <= long_next;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_fire) begin
         rsp_ff <= upd.word;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.hazard         = rsp_ff.hazard;
   assign rsp_chan.pending        = rsp_ff.pending;
   assign rsp_chan.long_op        = rsp_ff.long_op;
   assign rsp_chan.double_reserve = rsp_ff.double_reserve;

endmodule

`default_nettype wire

// File: dv/warp_register_scoreboard_test.sv
// testbench for the warp register scoreboard: drives request words, checks every response
// word against a bitmap predictor; depends on wrs_pkg, wrs_if and warp_register_scoreboard
`timescale 1ns / 1ps

module warp_register_scoreboard_test;

   localparam int NUM_WARPS = 64;
   localparam int NUM_REGS  = 64;
   localparam int STALL_CYCLES = 300;

   typedef logic [wrs_pkg::FUNC_W-1:0] func_code_type;
   typedef logic [wrs_pkg::WARP_W-1:0] warp_num_type;
   typedef logic [wrs_pkg::REG_W-1:0]  reg_num_type;
   typedef logic [wrs_pkg::REGS_W-1:0] reg_set_type;

   // function codes with no operation behind them
   localparam func_code_type FUNC_SPARE_A = 3'd5;
   localparam func_code_type FUNC_SPARE_B = 3'd6;
   localparam func_code_type FUNC_SPARE_C = 3'd7;

   logic clock = 1'b0;
   logic reset;

   wrs_req_if req_chan ();
   wrs_rsp_if rsp_chan ();

   warp_register_scoreboard #(
      .NUM_WARPS(NUM_WARPS),
      .NUM_REGS (NUM_REGS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // predicted scoreboard state
   logic [63:0] pend_map [NUM_WARPS];
   logic [63:0] long_map [NUM_WARPS];

   // words waiting to be sent, responses waiting to arrive
   wrs_pkg::req_type request_words [$];
   wrs_pkg::rsp_type expected_flags [$];

   // last destination set reserved per warp, so releases mostly match reserves
   reg_set_type last_dst [NUM_WARPS];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic req_taken = 1'b0;
   logic long_stall_req = 1'b0;
   logic long_stall_done = 1'b0;
   int stall_left = 0;

   int mismatch_count = 0;
   int words_queued = 0;
   int words_sent = 0;
   int words_checked = 0;
   int hazards_seen = 0;
   int doubles_seen = 0;
   int long_hits = 0;

   always #6 clock = ~clock;

   // one-hot bit of a register; zero and out-of-range numbers name no register
   function automatic logic [63:0] reg_onehot(reg_num_type r);
      if (r == 0 || r >= NUM_REGS)
         return '0;
      return 64'd1 << r;
   endfunction

   // apply one word to the predicted bitmaps and give the response it should produce
   function automatic wrs_pkg::rsp_type score_word(wrs_pkg::req_type w);
      logic [63:0] dst_set;
      logic [63:0] touch_set;
      logic [63:0] bit_mask;
      wrs_pkg::rsp_type r;
      r = '0;
      dst_set = '0;
      touch_set = '0;
      if (w.warp < NUM_WARPS) begin
         case (w.func)
            wrs_pkg::FUNC_RESERVE: begin
               for (int s = 0; s < wrs_pkg::SLOTS; s++) begin
                  bit_mask = reg_onehot(w.dst_regs[s*wrs_pkg::REG_W +: wrs_pkg::REG_W]);
                  if ((bit_mask & (pend_map[w.warp] | dst_set)) != 0)
                     r.double_reserve = 1'b1;
                  dst_set |= bit_mask;
               end
               pend_map[w.warp] |= dst_set;
               if (w.long_load)
                  long_map[w.warp] |= dst_set;
            end
            wrs_pkg::FUNC_RELEASE: begin
               for (int s = 0; s < wrs_pkg::SLOTS; s++)
                  dst_set |= reg_onehot(w.dst_regs[s*wrs_pkg::REG_W +: wrs_pkg::REG_W]);
               pend_map[w.warp] &= ~dst_set;
               long_map[w.warp] &= ~dst_set;
            end
            wrs_pkg::FUNC_CHECK: begin
               for (int s = 0; s < wrs_pkg::SLOTS; s++) begin
                  touch_set |= reg_onehot(w.dst_regs[s*wrs_pkg::REG_W +: wrs_pkg::REG_W]);
                  touch_set |= reg_onehot(w.src_regs[s*wrs_pkg::REG_W +: wrs_pkg::REG_W]);
               end
               touch_set |= reg_onehot(w.pred_reg) | reg_onehot(w.addr_reg_a)
                          | reg_onehot(w.addr_reg_b);
               r.hazard = (pend_map[w.warp] & touch_set) != 0;
            end
            wrs_pkg::FUNC_LONG_QUERY: begin
               r.long_op = (long_map[w.warp] & reg_onehot(w.query_reg)) != 0;
            end
            default: ;
         endcase
         r.pending = pend_map[w.warp] != 0;
      end
      return r;
   endfunction

   function automatic reg_set_type regs4(reg_num_type a, reg_num_type b,
                                         reg_num_type c, reg_num_type d);
      return {d, c, b, a};
   endfunction

   task automatic push_word(func_code_type f, warp_num_type warp, reg_set_type dst,
                            reg_set_type src, reg_num_type pred,
                            reg_num_type ra, reg_num_type rb, logic ll,
                            reg_num_type q);
      wrs_pkg::req_type w;
      w.func = f;
      w.warp = warp;
      w.dst_regs = dst;
      w.src_regs = src;
      w.pred_reg = pred;
      w.addr_reg_a = ra;
      w.addr_reg_b = rb;
      w.long_load = ll;
      w.query_reg = q;
      request_words.push_back(w);
      words_queued++;
   endtask

   // register numbers crowd into a small pool so that hazards and double reserves happen
   function automatic reg_num_type pick_reg();
      int roll;
      roll = $urandom_range(99);
      if (roll < 15)
         return '0;
      if (roll < 75)
         return reg_num_type'($urandom_range(7, 1));
      return reg_num_type'($urandom_range(63));
   endfunction

   function automatic reg_set_type pick_regs4();
      return regs4(pick_reg(), pick_reg(), pick_reg(), pick_reg());
   endfunction

   task automatic queue_random_words(int count);
      int roll;
      warp_num_type warp;
      reg_set_type dst;
      wrs_pkg::func_type f;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         warp = ($urandom_range(99) < 75) ? warp_num_type'($urandom_range(3))
                                          : warp_num_type'($urandom_range(63));
         dst = pick_regs4();
         if (roll < 30) begin
            f = wrs_pkg::FUNC_RESERVE;
            last_dst[warp] = dst;
         end else if (roll < 55) begin
            f = wrs_pkg::FUNC_RELEASE;
            if ($urandom_range(99) < 70)
               dst = last_dst[warp];
         end else if (roll < 80) begin
            f = wrs_pkg::FUNC_CHECK;
         end else if (roll < 90) begin
            f = wrs_pkg::FUNC_PENDING;
         end else begin
            f = wrs_pkg::FUNC_LONG_QUERY;
         end
         push_word(f, warp, dst, pick_regs4(), pick_reg(), pick_reg(), pick_reg(),
                   1'($urandom_range(1)), pick_reg());
      end
   endtask

   // wait until every queued word has been taken and answered
   task automatic drain();
      do
         @(negedge clock);
      while (words_sent < words_queued || expected_flags.size() != 0);
   endtask

   task automatic check_field(string name, logic want, logic got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, want, got);
      end
   endtask

   // request driver: a new word once the previous one has been taken
   always @(negedge clock) begin : drive_requests
      wrs_pkg::req_type w;
      if (!reset && (!req_chan.valid || req_taken)) begin
         if (request_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            w = request_words.pop_front();
            req_chan.func       <= w.func;
            req_chan.warp       <= w.warp;
            req_chan.dst_regs   <= w.dst_regs;
            req_chan.src_regs   <= w.src_regs;
            req_chan.pred_reg   <= w.pred_reg;
            req_chan.addr_reg_a <= w.addr_reg_a;
            req_chan.addr_reg_b <= w.addr_reg_b;
            req_chan.long_load  <= w.long_load;
            req_chan.query_reg  <= w.query_reg;
            req_chan.valid      <= 1'b1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off on request
   always @(negedge clock) begin : drive_ready
      if (long_stall_req && !long_stall_done) begin
         stall_left = STALL_CYCLES;
         long_stall_done = 1'b1;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   // watch both channels: check responses, then predict for newly taken words
   always @(posedge clock) begin : watch_words
      wrs_pkg::req_type w;
      wrs_pkg::rsp_type want;
      wrs_pkg::rsp_type got;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.hazard = rsp_chan.hazard;
            got.pending = rsp_chan.pending;
            got.long_op = rsp_chan.long_op;
            got.double_reserve = rsp_chan.double_reserve;
            if (expected_flags.size() == 0) begin
               mismatch_count++;
               $display("%0t: response word with none expected, expected none actual %b",
                        $time, got);
            end else begin
               want = expected_flags.pop_front();
               check_field("hazard", want.hazard, got.hazard);
               check_field("pending", want.pending, got.pending);
               check_field("long_op", want.long_op, got.long_op);
               check_field("double_reserve", want.double_reserve, got.double_reserve);
               words_checked++;
               hazards_seen += want.hazard;
               doubles_seen += want.double_reserve;
               long_hits += want.long_op;
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            w.func = req_chan.func;
            w.warp = req_chan.warp;
            w.dst_regs = req_chan.dst_regs;
            w.src_regs = req_chan.src_regs;
            w.pred_reg = req_chan.pred_reg;
            w.addr_reg_a = req_chan.addr_reg_a;
            w.addr_reg_b = req_chan.addr_reg_b;
            w.long_load = req_chan.long_load;
            w.query_reg = req_chan.query_reg;
            expected_flags.push_back(score_word(w));
            words_sent++;
         end
      end
      req_taken <= req_chan.valid && req_chan.ready;
   end

   // stimulus and phase control
   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.func = wrs_pkg::FUNC_RESERVE;
      req_chan.warp = '0;
      req_chan.dst_regs = '0;
      req_chan.src_regs = '0;
      req_chan.pred_reg = '0;
      req_chan.addr_reg_a = '0;
      req_chan.addr_reg_b = '0;
      req_chan.long_load = 1'b0;
      req_chan.query_reg = '0;
      rsp_chan.ready = 1'b0;
      for (int i = 0; i < NUM_WARPS; i++) begin
         pend_map[i] = '0;
         long_map[i] = '0;
         last_dst[i] = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty scoreboard, each operation, double reserves, clear releases
      push_word(wrs_pkg::FUNC_PENDING, '0, '0, '0, '0, '0, '0, 1'b0, '0);
      push_word(wrs_pkg::FUNC_RESERVE, '0, regs4(6'd1, 6'd2, '0, '0), '0, '0, '0, '0,
                1'b1, '0);
      push_word(wrs_pkg::FUNC_LONG_QUERY, '0, '0, '0, '0, '0, '0, 1'b0, 6'd1);
      push_word(wrs_pkg::FUNC_LONG_QUERY, '0, '0, '0, '0, '0, '0, 1'b0, 6'd3);
      push_word(wrs_pkg::FUNC_LONG_QUERY, '0, '0, '0, '0, '0, '0, 1'b0, '0);
      push_word(wrs_pkg::FUNC_CHECK, '0, '0, regs4('0, '0, '0, 6'd2), '0, '0, '0, 1'b0, '0);
      push_word(wrs_pkg::FUNC_CHECK, '0, '0, '0, 6'd1, '0, '0, 1'b0, '0);
      push_word(wrs_pkg::FUNC_CHECK, '0, '0, '0, '0, 6'd2, '0, 1'b0, '0);
      push_word(wrs_pkg::FUNC_CHECK, '0, '0, '0, '0, '0, 6'd1, 1'b0, '0);
      push_word(wrs_pkg::FUNC_CHECK, '0, regs4('0, '0, 6'd2, '0), '0, '0, '0, '0, 1'b0, '0);
      push_word(wrs_pkg::FUNC_CHECK, '0, regs4(6'd3, 6'd4, '0, '0),
                regs4(6'd5, 6'd6, 6'd7, '0), 6'd8, 6'd9, 6'd10, 1'b0, '0);
      push_word(wrs_pkg::FUNC_RESERVE, '0, regs4('0, '0, '0, 6'd2), '0, '0, '0, '0,
                1'b0, '0);
      push_word(wrs_pkg::FUNC_RESERVE, 6'd63, regs4(6'd63, 6'd63, '0, '0), '0, '0, '0, '0,
                1'b0, '0);
      push_word(wrs_pkg::FUNC_LONG_QUERY, 6'd63, '0, '0, '0, '0, '0, 1'b0, 6'd63);
      push_word(wrs_pkg::FUNC_RELEASE, '0, regs4(6'd1, 6'd5, '0, '0), '0, '0, '0, '0,
                1'b0, '0);
      push_word(wrs_pkg::FUNC_LONG_QUERY, '0, '0, '0, '0, '0, '0, 1'b0, 6'd1);
      push_word(wrs_pkg::FUNC_PENDING, '0, '0, '0, '0, '0, '0, 1'b0, '0);
      // spare function codes change nothing and report only the pending flag
      push_word(FUNC_SPARE_A, '0, regs4(6'd3, '0, '0, '0), '1, '1, '1, '1, 1'b1, 6'd2);
      push_word(FUNC_SPARE_B, '0, regs4(6'd2, '0, '0, '0), '1, '1, '1, '1, 1'b1, 6'd2);
      push_word(FUNC_SPARE_C, 6'd5, '1, '1, '1, '1, '1, 1'b1, '1);
      push_word(wrs_pkg::FUNC_CHECK, '0, regs4(6'd2, 6'd3, '0, '0), '0, '0, '0, '0,
                1'b0, '0);
      push_word(wrs_pkg::FUNC_RELEASE, '0, regs4(6'd2, '0, '0, '0), '0, '0, '0, '0,
                1'b0, '0);
      push_word(wrs_pkg::FUNC_PENDING, '0, '0, '0, '0, '0, '0, 1'b0, '0);
      push_word(wrs_pkg::FUNC_RESERVE, 6'd63, '1, '1, '1, '1, '1, 1'b1, '1);
      push_word(wrs_pkg::FUNC_LONG_QUERY, 6'd63, '1, '1, '1, '1, '1, 1'b1, '1);
      push_word(wrs_pkg::FUNC_CHECK, 6'd63, '1, '1, '1, '1, '1, 1'b1, '1);
      push_word(wrs_pkg::FUNC_RELEASE, 6'd63, '1, '1, '1, '1, '1, 1'b1, '1);
      push_word(wrs_pkg::FUNC_PENDING, 6'd63, '0, '0, '0, '0, '0, 1'b0, '0);
      push_word(wrs_pkg::FUNC_RESERVE, 6'd1, '0, '0, '0, '0, '0, 1'b1, '0);
      drain();

      // sender mostly busy, receiver often stalled
      send_idle_pct = 20;
      recv_idle_pct = 67;
      queue_random_words(280);
      drain();

      // sender often idle, receiver mostly ready
      send_idle_pct = 67;
      recv_idle_pct = 20;
      queue_random_words(280);
      drain();

      // full rate, opened by a long receiver hold-off to back the block up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      long_stall_req = 1'b1;
      queue_random_words(290);
      drain();

      repeat (20) @(posedge clock);
      $display("covered %0d words over directed, throttled, stalled and full-rate phases",
               words_sent);
      $display("responses checked %0d: %0d hazards, %0d double reserves, %0d long-op hits",
               words_checked, hazards_seen, doubles_seen, long_hits);
      if (mismatch_count == 0 && expected_flags.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0t: %0d mismatches, %0d responses missing", $time, mismatch_count,
                  expected_flags.size());
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("%0t: timeout, %0d responses outstanding", $time, expected_flags.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
